FILE: rtl/core/bfee_pkg.sv
// Package: shared types and constants of the edge-extrapolated box filter.
package bfee_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int SAMPLE_W    = 18;
   localparam int RADIUS_W    = 11;
   localparam int SUM_W       = 40;
   localparam int DIV_W       = 42;
   localparam int WIN_W       = RADIUS_W + 2;
   localparam int SLOPE_LIMIT = 3277;
   localparam int ONE_Q15     = 32768;
   localparam int RADIUS_RESET = 100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRIME_RD,
      ST_PRIME_ACC,
      ST_READY,
      ST_DIV,
      ST_SLIDE_RD,
      ST_SLIDE_ACC,
      ST_OUT
   } state_type;

   // read operand selection for the datapath
   typedef enum logic [1:0] {
      RD_HEAD0,
      RD_HEAD1,
      RD_TAIL0,
      RD_TAIL1
   } rd_sel_type;

   typedef struct packed {
      logic        load_wr;      // write sample, bump length
      logic        load_clear;   // discard prior table
      logic        finish;       // compute radius, start end reads
      logic        end_rd;       // read an end sample
      rd_sel_type  end_sel;
      logic        prime_rd;     // read window position k for priming
      logic        prime_acc;    // add read value to sum
      logic        div_start;
      logic        slide_rd;     // read i-r / i+r+1
      logic        slide_acc;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic single;       // table of one sample
      logic prime_done;
      logic div_done;
      logic is_last;
      logic full;
   } sts_type;

endpackage

FILE: rtl/core/box_filter_edge_extrapolated_top.sv
// Top level: edge-extrapolated box filter, controller plus datapath.
//  channel | ports                                   | direction
//  request | req_valid req_stall req_action req_*    | in
//  response| rsp_valid rsp_stall rsp_sample_out ...  | out
//  config  | csr_we csr_wdata (filter radius)        | in
// A finishing load is followed by the end-sample reads (head, tail, a wait),
// window priming over 2r+1 positions and a state that flags the table ready;
// only then is the next transaction accepted (a one-sample table skips priming).
// A fetch starts the divider in its accepting cycle and runs 42 bit-serial divider
// steps, then loads the result as the window slide reads, and the slide accumulates;
// the final fetch skips the slide and a one-sample table answers without division.
// Synchronous active-high reset clears control; sample memory is not cleared.
// A response waits in its output register; req_stall holds while it is stalled.
module box_filter_edge_extrapolated_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic signed [17:0]  req_sample_in,
   input  logic                req_last_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [17:0]  rsp_sample_out,
   output logic                rsp_last_out,
   input  logic                csr_we,
   input  logic [10:0]         csr_wdata
);
   import bfee_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [RADIUS_W-1:0] radius_ff;

   // filter radius register, used at next table finish
   always_ff @(posedge clock) begin
      if (reset) radius_ff <= RADIUS_W'(RADIUS_RESET);
      else if (csr_we) radius_ff <= csr_wdata;
   end

   bfee_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_last_in,
      .rsp_valid, .rsp_stall, .cmd, .sts
   );

   bfee_datapath u_dp (
      .clock, .reset, .cmd, .sts, .radius_cfg(radius_ff),
      .sample_in(req_sample_in), .result_out(rsp_sample_out),
      .last_res(rsp_last_out)
   );

   // a response is only raised by a loaded output register
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load)) else $error("rsp without load");
   // no transaction accepted while a response is stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall) else $error("accept while stalled");
   // priming and division never overlap
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_start && cmd.prime_acc)) else $error("prime/div overlap");

endmodule

FILE: rtl/core/bfee_datapath.sv
// Datapath: sample memory, end slopes, running window sum and divider.
module bfee_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  bfee_pkg::cmd_type            cmd,
   output bfee_pkg::sts_type            sts,
   input  logic [10:0]                  radius_cfg,
   input  logic signed [17:0]           sample_in,
   output logic signed [17:0]           result_out,
   output logic                         last_res
);
   import bfee_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [TABLE_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_a_ff, rd_b_ff;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [RADIUS_W-1:0] rad_ff, rad_in;
   logic signed [SAMPLE_W-1:0] s0_ff, t1_ff;
   logic signed [SAMPLE_W-1:0] hs_ff, ts_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   // priming position counter, offset k = kc - r
   logic signed [CNT_W+1:0] kc_ff, kc_in;
   logic [1:0] pend_ff;    // which end read is in flight (head, tail)
   logic signed [CNT_W+1:0] pa_ff, pb_ff; // positions of reads in flight
   logic [DIV_W-1:0] rem_ff, quo_ff;
   logic [WIN_W:0]   den_ff;
   logic [5:0]       dcnt_ff;
   logic             dneg_ff, dbusy_ff;
   logic signed [SAMPLE_W-1:0] res_ff;
   logic             last_ff;

   function automatic logic signed [SAMPLE_W-1:0] clamp_sl(
      input logic signed [SAMPLE_W:0] d);
      if (d > SLOPE_LIMIT) return SAMPLE_W'(SLOPE_LIMIT);
      if (d < -SLOPE_LIMIT) return -SAMPLE_W'(SLOPE_LIMIT);
      return SAMPLE_W'(d);
   endfunction

   // value at position p given read data for in-table positions
   function automatic logic signed [SUM_W-1:0] val_at(
      input logic signed [CNT_W+1:0] p, input logic signed [SAMPLE_W-1:0] d,
      input logic [CNT_W-1:0] n, input logic signed [SAMPLE_W-1:0] s0,
      input logic signed [SAMPLE_W-1:0] t1, input logic signed [SAMPLE_W-1:0] hs,
      input logic signed [SAMPLE_W-1:0] ts);
      logic signed [CNT_W+1:0] tail_off;
      tail_off = p - $signed({2'b00, n}) + (CNT_W+2)'(1);
      if (p < 0) return SUM_W'(s0) + SUM_W'(hs) * SUM_W'(p);
      if (tail_off > 0) return SUM_W'(t1) + SUM_W'(ts) * SUM_W'(tail_off);
      return SUM_W'(d);
   endfunction

   logic [CNT_W-1:0] half;
   logic signed [CNT_W+1:0] rad_s, pos_a, pos_b;
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic rd_en;

   // radius bound from the length the table has after this load
   assign half  = (len_in - 1'b1) >> 1;
   assign rad_s = $signed({{(CNT_W+2-RADIUS_W){1'b0}}, rad_ff});

   always_comb begin
      pos_a = '0; pos_b = '0; rd_en = 1'b0;
      if (cmd.end_rd) begin
         rd_en = 1'b1;
         unique case (cmd.end_sel)
            RD_HEAD0: begin pos_a = '0; pos_b = (CNT_W+2)'(1); end
            default:  begin pos_a = $signed({2'b00, len_ff}) - (CNT_W+2)'(2);
                            pos_b = $signed({2'b00, len_ff}) - (CNT_W+2)'(1); end
         endcase
      end else if (cmd.prime_rd) begin
         rd_en = 1'b1; pos_a = kc_ff - rad_s; pos_b = pos_a;
      end else if (cmd.slide_rd) begin
         rd_en = 1'b1;
         pos_a = $signed({2'b00, idx_ff}) - rad_s;
         pos_b = $signed({2'b00, idx_ff}) + rad_s + (CNT_W+2)'(1);
      end
   end

   // clip to table for the memory address; outside values are extrapolated
   always_comb begin
      if (pos_a < 0) addr_a = '0;
      else if (pos_a >= $signed({2'b00, len_ff})) addr_a = ADDR_W'(len_ff - 1'b1);
      else addr_a = ADDR_W'(pos_a);
      if (pos_b < 0) addr_b = '0;
      else if (pos_b >= $signed({2'b00, len_ff})) addr_b = ADDR_W'(len_ff - 1'b1);
      else addr_b = ADDR_W'(pos_b);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && !(len_ff[CNT_W-1] && !cmd.load_clear))
         mem[cmd.load_clear ? '0 : ADDR_W'(len_ff)] <= sample_in;
      if (rd_en) begin
         rd_a_ff <= mem[addr_a];
         rd_b_ff <= mem[addr_b];
      end
   end

   logic signed [SUM_W-1:0] va, vb;
   assign va = val_at(pa_ff, rd_a_ff, len_ff, s0_ff, t1_ff, hs_ff, ts_ff);
   assign vb = val_at(pb_ff, rd_b_ff, len_ff, s0_ff, t1_ff, hs_ff, ts_ff);

   always_comb begin
      len_in = len_ff;
      if (cmd.load_wr) begin
         if (cmd.load_clear) len_in = CNT_W'(1);
         else if (!len_ff[CNT_W-1]) len_in = len_ff + 1'b1;
      end
      rad_in = rad_ff;
      if (cmd.finish)
         rad_in = ({2'b00, radius_cfg} > half) ? RADIUS_W'(half) : radius_cfg;
      idx_in = idx_ff;
      if (cmd.finish) idx_in = '0;
      else if (cmd.slide_acc) idx_in = idx_ff + 1'b1;
      kc_in = kc_ff;
      if (cmd.finish) kc_in = '0;
      else if (cmd.prime_rd) kc_in = kc_ff + (CNT_W+2)'(1);
      sum_in = sum_ff;
      if (cmd.finish) sum_in = '0;
      else if (cmd.prime_acc) sum_in = sum_ff + va;
      else if (cmd.slide_acc) sum_in = sum_ff - va + vb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; idx_ff <= '0; rad_ff <= '0; sum_ff <= '0; kc_ff <= '0;
         hs_ff <= '0; ts_ff <= '0; dbusy_ff <= 1'b0;
      end else begin
         len_ff <= len_in; idx_ff <= idx_in; rad_ff <= rad_in;
         sum_ff <= sum_in; kc_ff <= kc_in;
         if (pend_ff[0]) begin
            s0_ff <= rd_a_ff;
            hs_ff <= clamp_sl({rd_b_ff[SAMPLE_W-1], rd_b_ff}
                             - {rd_a_ff[SAMPLE_W-1], rd_a_ff});
         end
         if (pend_ff[1]) begin
            t1_ff <= rd_b_ff;
            ts_ff <= clamp_sl({rd_b_ff[SAMPLE_W-1], rd_b_ff}
                             - {rd_a_ff[SAMPLE_W-1], rd_a_ff});
         end
         // restoring divider: q = (2|s| + w) / (2w)
         if (cmd.div_start) begin
            dbusy_ff <= 1'b1;
            dneg_ff  <= sum_ff[SUM_W-1];
            rem_ff   <= '0;
            quo_ff   <= DIV_W'({(sum_ff[SUM_W-1] ? -sum_ff : sum_ff), 1'b0})
                        + DIV_W'({rad_ff, 1'b1});
            den_ff   <= {rad_ff, 2'b10};
            dcnt_ff  <= 6'(DIV_W);
         end else if (dbusy_ff) begin
            logic [DIV_W:0] tr;
            tr = {rem_ff, quo_ff[DIV_W-1]} - (DIV_W+1)'(den_ff);
            if (!tr[DIV_W]) begin
               rem_ff <= tr[DIV_W-1:0]; quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
               quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 1'b1;
            if (dcnt_ff == 6'd1) dbusy_ff <= 1'b0;
         end
      end
   end

   // position/end-read tracking for the registered read data
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else begin
         pend_ff[0] <= cmd.end_rd && (cmd.end_sel == RD_HEAD0);
         pend_ff[1] <= cmd.end_rd && (cmd.end_sel != RD_HEAD0);
      end
      pa_ff <= pos_a;
      pb_ff <= pos_b;
   end

   logic [CNT_W-1:0] prime_total;
   assign prime_total = CNT_W'({rad_ff, 1'b1});

   logic signed [SAMPLE_W:0] mean;
   always_comb begin
      if (quo_ff > DIV_W'(ONE_Q15)) mean = (SAMPLE_W+1)'(ONE_Q15);
      else mean = (SAMPLE_W+1)'(quo_ff);
      if (dneg_ff) mean = -mean;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (len_ff < 2) begin
            res_ff <= rd_a_ff; last_ff <= 1'b1;
         end else begin
            res_ff <= SAMPLE_W'(mean);
            last_ff <= (idx_ff + 1'b1 >= len_ff);
         end
      end
   end

   assign sts.single     = (len_ff < 2);
   assign sts.prime_done = (kc_ff == $signed({2'b00, prime_total}));
   assign sts.div_done   = !dbusy_ff && !cmd.div_start;
   assign sts.is_last    = (idx_ff + 1'b1 >= len_ff);
   assign sts.full       = len_ff[CNT_W-1];
   assign result_out = res_ff;
   assign last_res   = last_ff;

endmodule

FILE: rtl/core/bfee_ctrl.sv
// Controller: sequences loading, priming, division and sliding.
module bfee_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic                 req_last_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bfee_pkg::cmd_type    cmd,
   input  bfee_pkg::sts_type    sts
);
   import bfee_pkg::*;

   state_type state_ff, state_in;
   logic ready_ff, ready_in;     // finished table pending
   logic [1:0] fin_ff, fin_in;   // end-read phase after finish
   logic vld_ff, vld_in;
   logic acc;

   assign req_stall = (state_ff != ST_IDLE) || (vld_ff && rsp_stall);
   assign acc = req_valid && !req_stall;
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && !req_action && req_last_in) state_in = ST_PRIME_RD;
            else if (acc && req_action && ready_ff)
               state_in = sts.single ? ST_OUT : ST_DIV;
         end
         ST_PRIME_RD:  state_in = (fin_ff != 2'd3) ? ST_PRIME_RD :
                                  sts.single ? ST_IDLE : ST_PRIME_ACC;
         ST_PRIME_ACC: state_in = sts.prime_done ? ST_READY : ST_PRIME_ACC;
         ST_READY:     state_in = ST_IDLE;
         ST_DIV:       state_in = sts.div_done ? (sts.is_last ? ST_OUT : ST_SLIDE_RD)
                                               : ST_DIV;
         ST_SLIDE_RD:  state_in = ST_SLIDE_ACC;
         ST_SLIDE_ACC: state_in = ST_IDLE;
         ST_OUT:       state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.end_sel = RD_HEAD0;
      fin_in = fin_ff;
      ready_in = ready_ff;
      vld_in = vld_ff && rsp_stall;
      if (acc && !req_action) begin
         cmd.load_wr = 1'b1;
         // only a pending finished table is discarded; otherwise samples append
         cmd.load_clear = ready_ff;
         ready_in = 1'b0;
         if (req_last_in) begin cmd.finish = 1'b1; fin_in = '0; end
      end
      unique case (state_ff)
         ST_PRIME_RD: begin
            // cycles: head read, tail read, wait, then priming
            if (fin_ff == 2'd0) begin cmd.end_rd = 1'b1; cmd.end_sel = RD_HEAD0; end
            if (fin_ff == 2'd1) begin cmd.end_rd = 1'b1; cmd.end_sel = RD_TAIL0; end
            if (fin_ff != 2'd3) fin_in = fin_ff + 2'd1;
            else if (sts.single) begin
               ready_in = 1'b1;
               cmd.prime_rd = 1'b0;
            end else cmd.prime_rd = 1'b1;
         end
         ST_PRIME_ACC: begin
            cmd.prime_acc = 1'b1;
            cmd.prime_rd = !sts.prime_done;
         end
         ST_READY: ready_in = 1'b1;
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.out_load = 1'b1; vld_in = 1'b1;
               if (sts.is_last) ready_in = 1'b0;
               else cmd.slide_rd = 1'b1;
            end
         end
         ST_SLIDE_RD: cmd.slide_acc = 1'b1;
         ST_OUT: begin
            if (sts.single) begin
               cmd.out_load = 1'b1; vld_in = 1'b1; ready_in = 1'b0;
            end
         end
         default: ;
      endcase
      if (state_ff == ST_IDLE && acc && req_action && ready_ff && !sts.single)
         cmd.div_start = 1'b1;
      if (state_ff == ST_IDLE && acc && req_action && ready_ff && sts.single) begin
         cmd.end_rd = 1'b1; cmd.end_sel = RD_HEAD0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ready_ff <= 1'b0;
         fin_ff <= '0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ready_ff <= ready_in;
         fin_ff <= fin_in; vld_ff <= vld_in;
      end
   end

endmodule

FILE: tb/sv/tb.sv
// Testbench for the edge-extrapolated box filter: directed table then random tables.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bfee_pkg::*;

   localparam int CYCLE_LIMIT = 20000;
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_FETCH = 1'b1;

   logic clock;
   logic reset;
   logic req_valid, req_stall, req_action, req_last_in;
   logic signed [17:0] req_sample_in;
   logic rsp_valid, rsp_stall, rsp_last_out;
   logic signed [17:0] rsp_sample_out;
   logic csr_we;
   logic [10:0] csr_wdata;

   box_filter_edge_extrapolated_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_sample_in(req_sample_in), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out), .rsp_last_out(rsp_last_out),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   typedef struct {
      logic signed [17:0] smp;
      logic               lst;
   } smooth_t;

   // directed row: fixed expectation only where obvious
   typedef struct {
      logic               act;
      logic signed [17:0] smp;
      logic               lst;
      logic               fixed;
      logic signed [17:0] exp_smp;
   } row_t;

   // shadow of the filter state
   int      tbl [TABLE_DEPTH];
   int      tbl_len;
   int      rd_pos;
   bit      tbl_rdy;
   int      eff_rad;
   int      slope_hd, slope_tl;
   longint  win_sum;
   int      radius_reg;

   smooth_t smooth_q[$];
   int      fixed_q[$];   // -1: use predictor value, else fixed sample value
   int      errors;
   int      idle_cycles;
   bit      hold_off;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clip_slope(int d);
      if (d > SLOPE_LIMIT) return SLOPE_LIMIT;
      if (d < -SLOPE_LIMIT) return -SLOPE_LIMIT;
      return d;
   endfunction

   function automatic longint curve_at(longint k);
      if (k < 0) return longint'(tbl[0]) + longint'(slope_hd) * k;
      if (k >= tbl_len)
         return longint'(tbl[tbl_len-1]) + longint'(slope_tl) * (k - (tbl_len - 1));
      return longint'(tbl[k]);
   endfunction

   function automatic int rounded_mean();
      longint w, mag, q, m;
      w   = 2 * eff_rad + 1;
      mag = (win_sum < 0) ? -win_sum : win_sum;
      q   = (2 * mag + w) / (2 * w);
      m   = (win_sum < 0) ? -q : q;
      if (m > ONE_Q15) m = ONE_Q15;
      if (m < -ONE_Q15) m = -ONE_Q15;
      return int'(m);
   endfunction

   // predictor: update shadow state, queue a smoothed sample if one results
   task automatic smooth_predict(input logic act, input logic signed [17:0] smp,
                                 input logic lst, input int fixed_val);
      smooth_t s;
      if (act == ACT_LOAD) begin
         if (tbl_rdy) begin
            tbl_rdy = 0; tbl_len = 0; rd_pos = 0;
         end
         if (tbl_len < TABLE_DEPTH) begin
            tbl[tbl_len] = smp;
            tbl_len++;
         end
         if (lst) begin
            tbl_rdy = 1; rd_pos = 0;
            if (tbl_len >= 2) begin
               eff_rad = radius_reg;
               if (eff_rad > (tbl_len - 1) / 2) eff_rad = (tbl_len - 1) / 2;
               slope_hd = clip_slope(tbl[1] - tbl[0]);
               slope_tl = clip_slope(tbl[tbl_len-1] - tbl[tbl_len-2]);
               win_sum = 0;
               for (int k = -eff_rad; k <= eff_rad; k++) win_sum += curve_at(k);
            end
         end
         return;
      end
      if (!tbl_rdy) return;
      if (tbl_len < 2) begin
         s.smp = 18'(tbl[0]); s.lst = 1; tbl_rdy = 0;
      end else begin
         s.smp = 18'(rounded_mean());
         if (rd_pos + 1 < tbl_len) begin
            win_sum -= curve_at(rd_pos - eff_rad);
            win_sum += curve_at(rd_pos + eff_rad + 1);
            rd_pos++;
            s.lst = 0;
         end else begin
            s.lst = 1; tbl_rdy = 0;
         end
      end
      smooth_q.push_back(s);
      fixed_q.push_back(fixed_val);
   endtask

   // send one transaction; predict at acceptance. Valid stays up for a
   // back-to-back transaction and drops only before an idle gap.
   task automatic send_txn(input logic act, input logic signed [17:0] smp,
                           input logic lst, input int fixed_val);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_sample_in <= smp;
      req_last_in   <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      smooth_predict(act, smp, lst, fixed_val);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (smooth_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_radius(input int v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v[10:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      radius_reg = v;
   endtask

   function automatic logic signed [17:0] rand_sample(int style);
      // mostly smooth curve values near [-1,1], sometimes full range
      if (style == 0) return 18'($urandom_range(0, 262143));
      return $signed(18'($urandom_range(0, 65536))) - 18'sd32768;
   endfunction

   // one table: load n samples then fetch, optionally with noise
   task automatic run_table(input int n, input bit full_range, input int extra_fetch);
      logic signed [17:0] v;
      v = rand_sample(full_range ? 0 : 1);
      for (int i = 0; i < n; i++) begin
         if (!full_range && $urandom_range(0, 9) != 0)
            v = v + $signed(18'($urandom_range(0, 8000))) - 18'sd4000;
         else
            v = rand_sample(full_range ? 0 : 1);
         send_txn(ACT_LOAD, v, i == n - 1, -1);
      end
      for (int i = 0; i < n + extra_fetch; i++)
         send_txn(ACT_FETCH, 18'($urandom_range(0, 262143)), 1'($urandom_range(0, 1)),
                  -1);
   endtask

   // response side: random stall, plus one long hold-off
   initial begin
      int gap;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         gap = $urandom_range(0, 8);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   // checker: compare each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (smooth_q.size() == 0) begin
            $error("unexpected result sample_out=%0d last_out=%0b",
                   rsp_sample_out, rsp_last_out);
            errors++;
         end else begin
            smooth_t s;
            int f;
            s = smooth_q.pop_front();
            f = fixed_q.pop_front();
            if (f != -1 && f != int'(s.smp)) begin
               $error("table row sample_out expected %0d predictor %0d", f, s.smp);
               errors++;
            end
            if (rsp_sample_out !== s.smp) begin
               $error("sample_out expected %0d actual %0d", s.smp, rsp_sample_out);
               errors++;
            end
            if (rsp_last_out !== s.lst) begin
               $error("last_out expected %0b actual %0b", s.lst, rsp_last_out);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles without any accepted transaction or response
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= CYCLE_LIMIT) begin
         $display("box_filter_edge_extrapolated_top: mismatch");
         $finish;
      end
   end

   initial begin
      row_t rows[$];
      int   total;
      errors = 0; idle_cycles = 0; hold_off = 0;
      tbl_len = 0; rd_pos = 0; tbl_rdy = 0; eff_rad = 0;
      slope_hd = 0; slope_tl = 0; win_sum = 0; radius_reg = RADIUS_RESET;
      reset = 1'b1;
      req_valid = 1'b0; req_action = ACT_LOAD; req_sample_in = '0; req_last_in = 1'b0;
      csr_we = 1'b0; csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: fetch with nothing ready, single-sample table at the top,
      // a sample appended after its drain, short tables, reload over a
      // pending table, drain past the end
      rows = '{
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b0, 18'sd0},
         '{ACT_LOAD,  18'sd131071,  1'b1, 1'b0, 18'sd0},
         '{ACT_FETCH, -18'sd1,      1'b1, 1'b1, 18'sd131071},
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b0, 18'sd0},
         '{ACT_LOAD,  -18'sd131072, 1'b1, 1'b0, 18'sd0},
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b1, 18'sd32768},
         '{ACT_LOAD,  18'sd131071,  1'b0, 1'b0, 18'sd0},
         '{ACT_LOAD,  18'sd131071,  1'b1, 1'b0, 18'sd0},
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b1, 18'sd32768},
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b1, 18'sd32768},
         '{ACT_LOAD,  -18'sd131072, 1'b0, 1'b0, 18'sd0},
         '{ACT_LOAD,  18'sd131071,  1'b0, 1'b0, 18'sd0},
         '{ACT_LOAD,  -18'sd131072, 1'b1, 1'b0, 18'sd0},
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b0, 18'sd0},
         '{ACT_LOAD,  18'sd1000,    1'b0, 1'b0, 18'sd0},
         '{ACT_LOAD,  18'sd5000,    1'b0, 1'b0, 18'sd0},
         '{ACT_LOAD,  -18'sd9000,   1'b0, 1'b0, 18'sd0},
         '{ACT_LOAD,  18'sd200,     1'b1, 1'b0, 18'sd0},
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b0, 18'sd0},
         '{ACT_FETCH, 18'sd0,       1'b1, 1'b0, 18'sd0},
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b0, 18'sd0},
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b0, 18'sd0},
         '{ACT_FETCH, 18'sd0,       1'b0, 1'b0, 18'sd0}
      };
      foreach (rows[i])
         send_txn(rows[i].act, rows[i].smp, rows[i].lst,
                  rows[i].fixed ? int'(rows[i].exp_smp) : -1);
      wait_drained();

      // radius extremes on short tables
      write_radius(0);
      run_table(9, 1'b1, 1);
      wait_drained();
      write_radius(2047);
      run_table(12, 1'b1, 0);
      wait_drained();

      // long hold-off while the sender keeps offering fetches
      write_radius(3);
      hold_off = 1;
      run_table(30, 1'b0, 2);
      wait_drained();

      // random phases with varying radius
      total = 0;
      while (total < 2000) begin
         int n;
         case ($urandom_range(0, 3))
            0: write_radius(0);
            1: write_radius($urandom_range(1, 8));
            2: write_radius($urandom_range(0, 2047));
            default: write_radius(RADIUS_RESET);
         endcase
         for (int t = 0; t < 4; t++) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 40);
            if ($urandom_range(0, 15) == 0) begin
               // broken sequence: stray loads and fetches in random order, then a restart
               for (int i = 0; i < 3; i++)
                  send_txn(1'($urandom_range(0, 1)), 18'($urandom_range(0, 262143)),
                           1'b0, -1);
            end
            run_table(n, $urandom_range(0, 4) == 0, $urandom_range(0, 1));
            total += 2 * n;
         end
         wait_drained();
      end

      wait_drained();
      if (errors == 0 && smooth_q.size() == 0)
         $display("box_filter_edge_extrapolated_top: match");
      else
         $display("box_filter_edge_extrapolated_top: mismatch");
      $finish;
   end
endmodule

FILE: sim.f
rtl/core/bfee_pkg.sv
rtl/core/bfee_datapath.sv
rtl/core/bfee_ctrl.sv
rtl/core/box_filter_edge_extrapolated_top.sv
tb/sv/tb.sv
